@@ src/udf_pkg.sv @@
// Shared types and constants for the unsigned decimal field formatter.
`default_nettype none

package udf_pkg;

    // Input field widths
    localparam int VALUE_W     = 64;
    localparam int SIZE_W      = 3;
    localparam int CNT_W       = 7;
    localparam int PREC_W      = 8;
    localparam int CHAR_W      = 8;

    // Decimal digit store
    localparam int DIGIT_W     = 4;
    localparam int NUM_DIGITS  = 20;
    localparam int BCD_W       = NUM_DIGITS * DIGIT_W;
    localparam int ND_W        = $clog2(NUM_DIGITS + 1);

    // Field limit default
    localparam int MAX_FIELD_DEF = 64;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Size modifier codes; any other code truncates as int
    localparam logic [SIZE_W-1:0] SIZE_INT   = 3'd0;
    localparam logic [SIZE_W-1:0] SIZE_CHAR  = 3'd1;
    localparam logic [SIZE_W-1:0] SIZE_SHORT = 3'd2;
    localparam logic [SIZE_W-1:0] SIZE_LONG  = 3'd3;
    localparam logic [SIZE_W-1:0] SIZE_LLONG = 3'd4;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] t_bcd;

    // One classified conversion, ready to be written out
    typedef struct packed {
        t_bcd             bcd;
        logic [ND_W-1:0]  nd;
        logic [CNT_W-1:0] lead;
        logic [CNT_W-1:0] pz;
        logic [CNT_W-1:0] trail;
        logic             zero_lead;
    } t_job;

endpackage

`default_nettype wire

@@ src/udf_front.sv @@
// Front end: accepts an item, converts it to BCD and works out the field layout.
`default_nettype none

module udf_front
    import udf_pkg::*;
#(
    parameter int P_MAX_FIELD = MAX_FIELD_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [VALUE_W-1:0] i_value,
    input  wire logic [SIZE_W-1:0]  i_size_mode,
    input  wire logic [CNT_W-1:0]   i_field_width,
    input  wire logic [PREC_W-1:0]  i_precision,
    input  wire logic               i_left_align,
    input  wire logic               i_zero_pad,
    output logic                    o_push,
    output t_job                    o_job,
    input  wire logic               i_full
);

    localparam int ITER_W = $clog2(VALUE_W);
    localparam logic [CNT_W-1:0] MAX_F = CNT_W'(P_MAX_FIELD);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CONV = 3'b010,
        S_PUSH = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [VALUE_W-1:0] r_bin, n_bin;
    t_bcd               r_bcd, n_bcd;
    logic [ITER_W-1:0]  r_iter, n_iter;
    logic [CNT_W-1:0]   r_width, n_width;
    logic [CNT_W-1:0]   r_prec, n_prec;
    logic               r_has_prec, n_has_prec;
    logic               r_left, n_left;
    logic               r_zero, n_zero;

    logic               accept;
    logic [VALUE_W-1:0] trunc;
    t_bcd               adj;
    logic [BCD_W:0]     shifted;
    logic [ND_W-1:0]    nd_found;
    logic [ND_W-1:0]    nd;
    logic [CNT_W-1:0]   pz;
    logic [CNT_W-1:0]   body;
    logic [CNT_W-1:0]   pad;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    // Size truncation
    always_comb begin
        unique case (i_size_mode)
            SIZE_CHAR:             trunc = {{(VALUE_W-8){1'b0}}, i_value[7:0]};
            SIZE_SHORT:            trunc = {{(VALUE_W-16){1'b0}}, i_value[15:0]};
            SIZE_LONG, SIZE_LLONG: trunc = i_value;
            default:               trunc = {{(VALUE_W-32){1'b0}}, i_value[31:0]};
        endcase
    end

    // One double-dabble step: add three to each digit of five or more, then shift
    always_comb begin
        for (int k = 0; k < NUM_DIGITS; k++) begin
            adj[k] = (r_bcd[k] >= 4'd5) ? r_bcd[k] + 4'd3 : r_bcd[k];
        end
        shifted = {adj, r_bin[VALUE_W-1]};
    end

    // Layout of the field from the finished digits
    always_comb begin
        nd_found = '0;
        for (int k = 0; k < NUM_DIGITS; k++) begin
            if (r_bcd[k] != '0) begin
                nd_found = ND_W'(k + 1);
            end
        end
        if (nd_found != '0) begin
            nd = nd_found;
        end else if (r_has_prec && (r_prec == '0)) begin
            nd = '0;
        end else begin
            nd = ND_W'(1);
        end
        if (r_has_prec && (r_prec > CNT_W'(nd))) begin
            pz = r_prec - CNT_W'(nd);
        end else begin
            pz = '0;
        end
        body = pz + CNT_W'(nd);
        pad  = (r_width > body) ? r_width - body : '0;
    end

    assign o_push          = (r_state == S_PUSH) && !i_full;
    assign o_job.bcd       = r_bcd;
    assign o_job.nd        = nd;
    assign o_job.pz        = pz;
    assign o_job.lead      = r_left ? '0 : pad;
    assign o_job.trail     = r_left ? pad : '0;
    assign o_job.zero_lead = !r_has_prec && r_zero;

    always_comb begin
        n_state    = r_state;
        n_bin      = r_bin;
        n_bcd      = r_bcd;
        n_iter     = r_iter;
        n_width    = r_width;
        n_prec     = r_prec;
        n_has_prec = r_has_prec;
        n_left     = r_left;
        n_zero     = r_zero;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state    = S_CONV;
                    n_bin      = trunc;
                    n_bcd      = '0;
                    n_iter     = '0;
                    n_width    = (i_field_width > MAX_F) ? MAX_F : i_field_width;
                    n_has_prec = !i_precision[PREC_W-1];
                    n_prec     = (i_precision[PREC_W-2:0] > MAX_F) ? MAX_F
                                                               : i_precision[PREC_W-2:0];
                    n_left     = i_left_align;
                    n_zero     = i_zero_pad;
                end
            end
            S_CONV: begin
                n_bcd  = shifted[BCD_W-1:0];
                n_bin  = {r_bin[VALUE_W-2:0], 1'b0};
                n_iter = r_iter + 1'b1;
                if (r_iter == ITER_W'(VALUE_W - 1)) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (!i_full) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_bin      <= n_bin;
        r_bcd      <= n_bcd;
        r_iter     <= n_iter;
        r_width    <= n_width;
        r_prec     <= n_prec;
        r_has_prec <= n_has_prec;
        r_left     <= n_left;
        r_zero     <= n_zero;
    end

    a_accept_starts_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_CONV) && (r_iter == '0))
        else $error("front did not start conversion after accepting an item");

    a_job_fits_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (nd <= ND_W'(NUM_DIGITS))
                   && ((CNT_W+1)'(pad) + (CNT_W+1)'(body) <= (CNT_W+1)'(P_MAX_FIELD)))
        else $error("classified conversion exceeds the field limit");

endmodule

`default_nettype wire

@@ src/udf_queue.sv @@
// Short job queue between the front end and the character writer.
`default_nettype none

module udf_queue
    import udf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_push_data,
    output logic      o_full,
    input  wire logic i_pop,
    output t_job      o_pop_data,
    output logic      o_empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    t_job              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_QW-1:0] r_count;

    assign o_full     = (r_count == CNT_QW'(QUEUE_DEPTH));
    assign o_empty    = (r_count == '0);
    assign o_pop_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !o_full) || (!i_push && (!i_pop || !o_empty)))
        else $error("queue pushed when full or popped when empty");

endmodule

`default_nettype wire

@@ src/udf_back.sv @@
// Back end: writes out one character per cycle for each queued conversion while the output is not stalled.
`default_nettype none

module udf_back
    import udf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_empty,
    input  wire t_job              i_job,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [CHAR_W-1:0]      o_out_char,
    output logic                   o_last
);

    logic               r_busy, n_busy;
    t_bcd               r_bcd, n_bcd;
    logic [CNT_W-1:0]   r_lead, n_lead;
    logic [CNT_W-1:0]   r_pz, n_pz;
    logic [ND_W-1:0]    r_nd, n_nd;
    logic [CNT_W-1:0]   r_trail, n_trail;
    logic [CNT_W-1:0]   r_rem, n_rem;
    logic               r_zero_lead, n_zero_lead;
    logic               r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]  r_out_char, n_out_char;
    logic               r_last, n_last;

    logic               emit;
    logic [CNT_W-1:0]   job_total;
    logic [ND_W-1:0]    digit_idx;

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_last      = r_last;

    assign o_pop     = !r_busy && !i_empty;
    assign emit      = r_busy && (!r_out_valid || !i_out_stall);
    assign job_total = i_job.lead + i_job.pz + CNT_W'(i_job.nd) + i_job.trail;
    assign digit_idx = r_nd - 1'b1;

    always_comb begin
        n_busy      = r_busy;
        n_bcd       = r_bcd;
        n_lead      = r_lead;
        n_pz        = r_pz;
        n_nd        = r_nd;
        n_trail     = r_trail;
        n_rem       = r_rem;
        n_zero_lead = r_zero_lead;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_char  = r_out_char;
        n_last      = r_last;
        if (o_pop) begin
            // an empty conversion is dropped here
            n_busy      = (job_total != '0);
            n_bcd       = i_job.bcd;
            n_lead      = i_job.lead;
            n_pz        = i_job.pz;
            n_nd        = i_job.nd;
            n_trail     = i_job.trail;
            n_rem       = job_total;
            n_zero_lead = i_job.zero_lead;
        end else if (emit) begin
            n_out_valid = 1'b1;
            n_last      = (r_rem == CNT_W'(1));
            n_rem       = r_rem - 1'b1;
            n_busy      = (r_rem != CNT_W'(1));
            priority if (r_lead != '0) begin
                n_out_char = r_zero_lead ? CHAR_ZERO : CHAR_SPACE;
                n_lead     = r_lead - 1'b1;
            end else if (r_pz != '0) begin
                n_out_char = CHAR_ZERO;
                n_pz       = r_pz - 1'b1;
            end else if (r_nd != '0) begin
                n_out_char = CHAR_ZERO | {{(CHAR_W-DIGIT_W){1'b0}}, r_bcd[digit_idx]};
                n_nd       = r_nd - 1'b1;
            end else begin
                n_out_char = CHAR_SPACE;
                n_trail    = r_trail - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
        r_bcd       <= n_bcd;
        r_lead      <= n_lead;
        r_pz        <= n_pz;
        r_nd        <= n_nd;
        r_trail     <= n_trail;
        r_rem       <= n_rem;
        r_zero_lead <= n_zero_lead;
        r_out_char  <= n_out_char;
        r_last      <= n_last;
    end

    a_rem_matches_segments: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem == r_lead + r_pz + CNT_W'(r_nd) + r_trail) && (r_rem != '0))
        else $error("remaining count out of step with the field segments");

    a_last_ends_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && (r_rem == CNT_W'(1))) |=> !r_busy && r_out_valid && r_last)
        else $error("final character did not close the conversion");

endmodule

`default_nettype wire

@@ src/unsigned_decimal_field_formatter_unit.sv @@
// Top level of the unsigned decimal field formatter (printf %u conversion).
`default_nettype none

// Each input item is one %u conversion: the value is truncated by the size
// modifier (char 8 bits, short 16, int 32, long and long long 64; unused codes
// act as int), converted to decimal and written out as a character stream of
// leading pad, precision zeros, digits and trailing spaces, one character per
// output item, with o_last on the final character. Width and precision
// saturate at P_MAX_FIELD; a negative precision means none was given, and the
// zero flag pads with '0' only without a precision and without left align. A
// zero value with precision 0 and width 0 produces no output items at all.
// The front end handles one item at a time: it accepts the item, runs 64
// shift-and-adjust steps of the binary-to-BCD converter, then hands the
// laid-out job to a two-entry queue. The back end pops a job and then emits
// max(width, digits, precision) characters at one per cycle while the output
// is not stalled. Both halves run at once.
module unsigned_decimal_field_formatter_unit
    import udf_pkg::*;
#(
    parameter int P_MAX_FIELD = MAX_FIELD_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input items
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [VALUE_W-1:0] i_value,
    input  wire logic [SIZE_W-1:0]  i_size_mode,
    input  wire logic [CNT_W-1:0]   i_field_width,
    input  wire logic [PREC_W-1:0]  i_precision,
    input  wire logic               i_left_align,
    input  wire logic               i_zero_pad,
    // output items
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [CHAR_W-1:0]       o_out_char,
    output logic                    o_last
);

    logic push;
    logic full;
    logic pop;
    logic empty;
    t_job push_job;
    t_job pop_job;

    // Accept, truncate, convert to BCD, then lay out pad / zeros / digits
    udf_front #(
        .P_MAX_FIELD (P_MAX_FIELD)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_value       (i_value),
        .i_size_mode   (i_size_mode),
        .i_field_width (i_field_width),
        .i_precision   (i_precision),
        .i_left_align  (i_left_align),
        .i_zero_pad    (i_zero_pad),
        .o_push        (push),
        .o_job         (push_job),
        .i_full        (full)
    );

    // Hold finished jobs so the front can start the next item early
    udf_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_job),
        .o_full      (full),
        .i_pop       (pop),
        .o_pop_data  (pop_job),
        .o_empty     (empty)
    );

    // Emit the characters of each job through a registered output stage
    udf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_job       (pop_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_char  (o_out_char),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire
